>>> hw/rtl/pcrp_pkg.sv
// Shared types, constants and arithmetic helpers for the pulley constraint row prep unit.
package pcrp_pkg;

  localparam int COORD_BITS = 21;
  localparam int CW         = COORD_BITS;
  localparam int FRAC_BITS  = 10;
  localparam int DIR_FRAC   = CW - 2;
  localparam int VEC_W      = 63;
  localparam int QUAT_W     = 64;
  localparam int QC_W       = 16;
  localparam int ROT_SHIFT  = 28;
  localparam int REST_W     = 22;
  localparam int RATIO_W    = 16;
  localparam int ERR_W      = 24;
  localparam int ERR_SHIFT  = 18;

  // front arithmetic widths
  localparam int TW = QC_W + CW + 1;   // q x v
  localparam int SW = QC_W + TW + 2;   // w*t + q x t

  // back arithmetic widths
  localparam int DW     = CW + 1;                          // rope vector component
  localparam int SUM_W  = 2 * DW + 2;                      // sum of squares
  localparam int REM_W  = 66;                              // sqrt remainder
  localparam int LEN_W  = 32;                              // rope length, 20 fraction bits
  localparam int SQ_N   = LEN_W;                           // one root bit per stage
  localparam int QB     = DIR_FRAC + 1;                    // quotient bits
  localparam int NUM_SH = DIR_FRAC + FRAC_BITS + 1;
  localparam int NUM_W  = DW + NUM_SH + 1;
  localparam int DEN_W  = LEN_W + 1;
  localparam int XP_W   = DW + CW;                         // rel * dir

  // back pipeline stage map
  localparam int ST_D   = 0;
  localparam int ST_SUM = 1;
  localparam int ST_SQ0 = 2;
  localparam int ST_E1  = ST_SQ0 + SQ_N;
  localparam int ST_E2  = ST_E1 + 1;
  localparam int ST_DV0 = ST_E2 + 1;
  localparam int ST_A1  = ST_DV0 + QB;
  localparam int ST_A2  = ST_A1 + 1;
  localparam int BK_N   = ST_A2 + 1;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_POINT_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_POINT_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULLEY_RATIO  = 3'd5;

  localparam logic [REST_W-1:0]  REST_RESET  = 22'd1024;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

  // impulse limit modes
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_PULL = 2'd1;
  localparam logic [1:0] MODE_ZERO = 2'd2;

  localparam logic signed [63:0] C_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] C_MIN = -(64'sd1 <<< (CW - 1));
  localparam logic signed [63:0] E_MAX = (64'sd1 <<< (ERR_W - 1)) - 64'sd1;
  localparam logic signed [63:0] E_MIN = -(64'sd1 <<< (ERR_W - 1));

  typedef struct packed {
    logic [VEC_W-1:0]  position_a;
    logic [QUAT_W-1:0] rotation_a;
    logic [VEC_W-1:0]  position_b;
    logic [QUAT_W-1:0] rotation_b;
  } in_item_t;

  typedef struct packed {
    logic [VEC_W-1:0] world_point_a;
    logic [VEC_W-1:0] world_point_b;
    logic [VEC_W-1:0] offset_a;
    logic [VEC_W-1:0] direction_a;
    logic [VEC_W-1:0] angular_a;
    logic [VEC_W-1:0] direction_b;
    logic [VEC_W-1:0] angular_b;
    logic [ERR_W-1:0] length_error;
    logic [1:0]       impulse_mode;
  } out_item_t;

  typedef struct packed {
    logic [VEC_W-1:0]   anchor_a;
    logic [VEC_W-1:0]   anchor_b;
    logic [REST_W-1:0]  rest_length;
    logic [RATIO_W-1:0] pulley_ratio;
  } cfg_t;

  // front to back queue entry
  typedef struct packed {
    logic [VEC_W-1:0]     wa;
    logic [VEC_W-1:0]     wb;
    logic [VEC_W-1:0]     off;
    logic [2:0][DW-1:0]   rel_a;
    logic [2:0][DW-1:0]   rel_b;
  } fq_t;

  function automatic logic [CW-1:0] sat_c(input logic signed [63:0] x);
    logic [CW-1:0] r;
    if (x > C_MAX) r = C_MAX[CW-1:0];
    else if (x < C_MIN) r = C_MIN[CW-1:0];
    else r = x[CW-1:0];
    return r;
  endfunction

  function automatic logic [ERR_W-1:0] sat_e(input logic signed [63:0] x);
    logic [ERR_W-1:0] r;
    if (x > E_MAX) r = E_MAX[ERR_W-1:0];
    else if (x < E_MIN) r = E_MIN[ERR_W-1:0];
    else r = x[ERR_W-1:0];
    return r;
  endfunction

  // round half up, arithmetic shift
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int nxt3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int prv3(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

>>> hw/rtl/pcrp_front.sv
// Front end: configuration registers, pose intake and joint point transform pipeline.
module pcrp_front import pcrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  in_item_t             item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VEC_W-1:0]     cfg_data,
  output cfg_t                 cfg,
  output logic                 push,
  output fq_t                  push_data,
  input  logic                 fifo_full
);

  typedef struct packed {
    logic [1:0][VEC_W-1:0]    pos;
    logic [1:0][VEC_W-1:0]    v;
    logic [1:0][QUAT_W-1:0]   q;
    logic [1:0][2:0][TW-1:0]  t;
    logic [1:0][2:0][SW-1:0]  s;
    logic [1:0][VEC_W-1:0]    wp;
  } ft_t;

  logic [VEC_W-1:0] local_point_a;
  logic [VEC_W-1:0] local_point_b;

  ft_t  f1, f2, f3, f1_next, f2_next, f3_next;
  fq_t  f4, f4_next;
  logic v1, v2, v3, v4;
  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.anchor_a     <= '0;
      cfg.anchor_b     <= '0;
      local_point_a    <= '0;
      local_point_b    <= '0;
      cfg.rest_length  <= REST_RESET;
      cfg.pulley_ratio <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANCHOR_A:      cfg.anchor_a <= cfg_data;
        CFG_ANCHOR_B:      cfg.anchor_b <= cfg_data;
        CFG_LOCAL_POINT_A: local_point_a <= cfg_data;
        CFG_LOCAL_POINT_B: local_point_b <= cfg_data;
        CFG_REST_LENGTH:   cfg.rest_length <= cfg_data[REST_W-1:0];
        CFG_PULLEY_RATIO:  cfg.pulley_ratio <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !(v4 && fifo_full);
  assign item_stall = !adv;
  assign push       = v4 && adv;
  assign push_data  = f4;

  // stage 1: t = q x v
  always_comb begin
    logic signed [QC_W-1:0] qj, qk;
    logic signed [CW-1:0]   vj, vk;
    logic signed [TW-1:0]   tt;
    int j, k;
    f1_next        = '0;
    f1_next.pos[0] = item.position_a;
    f1_next.pos[1] = item.position_b;
    f1_next.q[0]   = item.rotation_a;
    f1_next.q[1]   = item.rotation_b;
    f1_next.v[0]   = local_point_a;
    f1_next.v[1]   = local_point_b;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        j  = nxt3(i);
        k  = prv3(i);
        qj = f1_next.q[b][QC_W*j +: QC_W];
        qk = f1_next.q[b][QC_W*k +: QC_W];
        vj = f1_next.v[b][CW*j +: CW];
        vk = f1_next.v[b][CW*k +: CW];
        tt = qj * vk - qk * vj;
        f1_next.t[b][i] = tt;
      end
    end
  end

  // stage 2: s = w*t + q x t
  always_comb begin
    logic signed [QC_W-1:0] qj, qk, w;
    logic signed [TW-1:0]   tj, tk, ti;
    logic signed [SW-1:0]   ss;
    int j, k;
    f2_next = f1;
    for (int b = 0; b < 2; b++) begin
      w = f1.q[b][QUAT_W-1 -: QC_W];
      for (int i = 0; i < 3; i++) begin
        j  = nxt3(i);
        k  = prv3(i);
        qj = f1.q[b][QC_W*j +: QC_W];
        qk = f1.q[b][QC_W*k +: QC_W];
        tj = f1.t[b][j];
        tk = f1.t[b][k];
        ti = f1.t[b][i];
        ss = w * ti + (qj * tk - qk * tj);
        f2_next.s[b][i] = ss;
      end
    end
  end

  // stage 3: round the rotated offset and add the position
  always_comb begin
    logic signed [63:0] v64, s64, p64, acc;
    f3_next = f2;
    for (int b = 0; b < 2; b++) begin
      f3_next.wp[b] = '0;
      for (int i = 0; i < 3; i++) begin
        v64 = $signed(f2.v[b][CW*i +: CW]);
        p64 = $signed(f2.pos[b][CW*i +: CW]);
        s64 = $signed(f2.s[b][i]);
        acc = (v64 <<< ROT_SHIFT) + (s64 <<< 1);
        f3_next.wp[b][CW*i +: CW] = sat_c(p64 + rshr(acc, ROT_SHIFT));
      end
    end
  end

  // stage 4: offsets against the body positions
  always_comb begin
    logic signed [63:0] wa64, wb64, pa64, pb64, ra, rb;
    f4_next     = '0;
    f4_next.wa  = f3.wp[0];
    f4_next.wb  = f3.wp[1];
    for (int i = 0; i < 3; i++) begin
      wa64 = $signed(f3.wp[0][CW*i +: CW]);
      wb64 = $signed(f3.wp[1][CW*i +: CW]);
      pa64 = $signed(f3.pos[0][CW*i +: CW]);
      pb64 = $signed(f3.pos[1][CW*i +: CW]);
      ra   = wa64 - pa64;
      rb   = wb64 - pb64;
      f4_next.off[CW*i +: CW] = sat_c(wb64 - pa64);
      f4_next.rel_a[i] = ra[DW-1:0];
      f4_next.rel_b[i] = rb[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= f1_next;
      f2 <= f2_next;
      f3 <= f3_next;
      f4 <= f4_next;
    end
  end

endmodule

>>> hw/rtl/pcrp_fifo.sv
// Short queue between the transform front end and the rope back end.
module pcrp_fifo import pcrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fq_t  din,
  output logic full,
  input  logic pop,
  output fq_t  dout,
  output logic valid
);

  fq_t              mem [FQ_DEPTH];
  logic [FQ_PW-1:0] wr_ptr, rd_ptr;
  logic [FQ_PW:0]   count;

  assign full  = (count == (FQ_PW+1)'(FQ_DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

>>> hw/rtl/pcrp_back.sv
// Back end: rope lengths, directions, angular terms and length error pipeline.
module pcrp_back import pcrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  fq_t       head,
  input  logic      head_valid,
  output logic      pop,
  input  cfg_t      cfg,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  typedef struct packed {
    logic [VEC_W-1:0]        wa;
    logic [VEC_W-1:0]        wb;
    logic [VEC_W-1:0]        off;
    logic [2:0][DW-1:0]      rel_a;
    logic [2:0][DW-1:0]      rel_b;
    logic [2:0][DW-1:0]      d_a;
    logic [2:0][DW-1:0]      d_b;
    logic [REM_W-1:0]        rem_a;
    logic [REM_W-1:0]        rem_b;
    logic [LEN_W-1:0]        root_a;
    logic [LEN_W-1:0]        root_b;
    logic [LEN_W+RATIO_W-1:0] prod_b;
    logic [ERR_W-1:0]        err;
    logic [1:0]              mode;
    logic [5:0][NUM_W-1:0]   drem;
    logic [5:0][QB-1:0]      dq;
    logic [DEN_W-1:0]        den_a;
    logic [DEN_W-1:0]        den_b;
    logic [5:0]              dneg;
    logic [VEC_W-1:0]        dir_a;
    logic [VEC_W-1:0]        dir_b;
    logic [5:0][XP_W-1:0]    xp_a;
    logic [5:0][XP_W-1:0]    xp_b;
    logic [VEC_W-1:0]        ang_a;
    logic [VEC_W-1:0]        ang_b;
  } bk_t;

  bk_t             bk [BK_N];
  logic [BK_N-1:0] bv;
  logic            adv;

  assign adv          = !bv[BK_N-1] || !result_stall;
  assign pop          = head_valid && adv;
  assign result_valid = bv[BK_N-1];

  always_ff @(posedge clk) begin
    if (rst) bv <= '0;
    else if (adv) bv <= {bv[BK_N-2:0], pop};
  end

  for (genvar k = 0; k < BK_N; k++) begin : g_st
    bk_t nx;

    if (k == ST_D) begin : g_d
      // rope vectors, anchor minus joint
      always_comb begin
        logic signed [63:0] an, jp, dd;
        nx       = '0;
        nx.wa    = head.wa;
        nx.wb    = head.wb;
        nx.off   = head.off;
        nx.rel_a = head.rel_a;
        nx.rel_b = head.rel_b;
        for (int i = 0; i < 3; i++) begin
          an = $signed(cfg.anchor_a[CW*i +: CW]);
          jp = $signed(head.wa[CW*i +: CW]);
          dd = an - jp;
          nx.d_a[i] = dd[DW-1:0];
          an = $signed(cfg.anchor_b[CW*i +: CW]);
          jp = $signed(head.wb[CW*i +: CW]);
          dd = an - jp;
          nx.d_b[i] = dd[DW-1:0];
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        logic signed [DW-1:0] da, db;
        logic signed [2*DW-1:0] pa, pb;
        logic [SUM_W-1:0] sa, sb;
        nx = bk[k-1];
        sa = '0;
        sb = '0;
        for (int i = 0; i < 3; i++) begin
          da = bk[k-1].d_a[i];
          db = bk[k-1].d_b[i];
          pa = da * da;
          pb = db * db;
          sa = sa + SUM_W'(unsigned'(pa));
          sb = sb + SUM_W'(unsigned'(pb));
        end
        nx.rem_a  = REM_W'(sa) << 20;
        nx.rem_b  = REM_W'(sb) << 20;
        nx.root_a = '0;
        nx.root_b = '0;
      end
    end else if (k >= ST_SQ0 && k < ST_E1) begin : g_sq
      // one root bit per stage: (r + 2^i)^2 = r^2 + r*2^(i+1) + 2^(2i)
      localparam int I = SQ_N - 1 - (k - ST_SQ0);
      always_comb begin
        logic [REM_W-1:0] ta, tb;
        nx = bk[k-1];
        ta = (REM_W'(bk[k-1].root_a) << (I + 1)) | (REM_W'(1) << (2 * I));
        tb = (REM_W'(bk[k-1].root_b) << (I + 1)) | (REM_W'(1) << (2 * I));
        if (bk[k-1].rem_a >= ta) begin
          nx.rem_a     = bk[k-1].rem_a - ta;
          nx.root_a[I] = 1'b1;
        end
        if (bk[k-1].rem_b >= tb) begin
          nx.rem_b     = bk[k-1].rem_b - tb;
          nx.root_b[I] = 1'b1;
        end
      end
    end else if (k == ST_E1) begin : g_e1
      always_comb begin
        nx        = bk[k-1];
        nx.prod_b = bk[k-1].root_b * cfg.pulley_ratio;
      end
    end else if (k == ST_E2) begin : g_e2
      // length error, and divider setup for the six direction lanes
      always_comb begin
        logic signed [63:0] e64, r64;
        logic signed [DW-1:0] dd;
        logic [DW-1:0] mag;
        logic [LEN_W-1:0] len;
        nx  = bk[k-1];
        e64 = $signed({42'd0, cfg.rest_length}) <<< ERR_SHIFT;
        e64 = e64 - ($signed({32'd0, bk[k-1].root_a}) <<< 8);
        e64 = e64 - $signed({16'd0, bk[k-1].prod_b});
        r64 = rshr(e64, ERR_SHIFT);
        nx.err = sat_e(r64);
        if (r64 < 0 && nx.err != '0) nx.mode = MODE_PUSH;
        else if (nx.err == '0) nx.mode = MODE_ZERO;
        else nx.mode = MODE_PULL;
        nx.den_a = {bk[k-1].root_a, 1'b0};
        nx.den_b = {bk[k-1].root_b, 1'b0};
        for (int j = 0; j < 6; j++) begin
          dd  = (j < 3) ? bk[k-1].d_a[j % 3] : bk[k-1].d_b[j % 3];
          len = (j < 3) ? bk[k-1].root_a : bk[k-1].root_b;
          mag = dd[DW-1] ? DW'(-dd) : DW'(dd);
          nx.dneg[j] = dd[DW-1];
          nx.drem[j] = (NUM_W'(mag) << NUM_SH) + NUM_W'(len);
          nx.dq[j]   = '0;
        end
      end
    end else if (k >= ST_DV0 && k < ST_A1) begin : g_dv
      // restoring division, one quotient bit per stage
      localparam int B = QB - 1 - (k - ST_DV0);
      always_comb begin
        logic [NUM_W-1:0] dsh;
        nx = bk[k-1];
        for (int j = 0; j < 6; j++) begin
          dsh = (j < 3) ? (NUM_W'(bk[k-1].den_a) << B) : (NUM_W'(bk[k-1].den_b) << B);
          if (bk[k-1].drem[j] >= dsh) begin
            nx.drem[j]  = bk[k-1].drem[j] - dsh;
            nx.dq[j][B] = 1'b1;
          end
        end
      end
    end else if (k == ST_A1) begin : g_a1
      // signed directions (B is negated) and cross product terms
      always_comb begin
        logic signed [CW-1:0] da [3];
        logic signed [CW-1:0] db [3];
        logic signed [CW-1:0] qv;
        logic signed [DW-1:0] rj, rk;
        logic signed [XP_W-1:0] p1, p2;
        int j, m;
        nx       = bk[k-1];
        nx.dir_a = '0;
        nx.dir_b = '0;
        for (int i = 0; i < 3; i++) begin
          qv = $signed(CW'(bk[k-1].dq[i]));
          if (bk[k-1].root_a == '0) da[i] = '0;
          else da[i] = bk[k-1].dneg[i] ? -qv : qv;
          qv = $signed(CW'(bk[k-1].dq[i+3]));
          if (bk[k-1].root_b == '0) db[i] = '0;
          else db[i] = bk[k-1].dneg[i+3] ? qv : -qv;
          nx.dir_a[CW*i +: CW] = da[i];
          nx.dir_b[CW*i +: CW] = db[i];
        end
        for (int i = 0; i < 3; i++) begin
          j  = nxt3(i);
          m  = prv3(i);
          rj = bk[k-1].rel_a[j];
          rk = bk[k-1].rel_a[m];
          p1 = rj * da[m];
          p2 = rk * da[j];
          nx.xp_a[i]   = p1;
          nx.xp_a[i+3] = p2;
          rj = bk[k-1].rel_b[j];
          rk = bk[k-1].rel_b[m];
          p1 = rj * db[m];
          p2 = rk * db[j];
          nx.xp_b[i]   = p1;
          nx.xp_b[i+3] = p2;
        end
      end
    end else begin : g_a2
      always_comb begin
        logic signed [63:0] c;
        nx       = bk[k-1];
        nx.ang_a = '0;
        nx.ang_b = '0;
        for (int i = 0; i < 3; i++) begin
          c = $signed(bk[k-1].xp_a[i]) - $signed(bk[k-1].xp_a[i+3]);
          nx.ang_a[CW*i +: CW] = sat_c(rshr(c, DIR_FRAC));
          c = $signed(bk[k-1].xp_b[i]) - $signed(bk[k-1].xp_b[i+3]);
          nx.ang_b[CW*i +: CW] = sat_c(rshr(c, DIR_FRAC));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) bk[k] <= nx;
    end
  end

  always_comb begin
    result.world_point_a = bk[BK_N-1].wa;
    result.world_point_b = bk[BK_N-1].wb;
    result.offset_a      = bk[BK_N-1].off;
    result.direction_a   = bk[BK_N-1].dir_a;
    result.angular_a     = bk[BK_N-1].ang_a;
    result.direction_b   = bk[BK_N-1].dir_b;
    result.angular_b     = bk[BK_N-1].ang_b;
    result.length_error  = bk[BK_N-1].err;
    result.impulse_mode  = bk[BK_N-1].mode;
  end

endmodule

>>> hw/rtl/pulley_constraint_row_prep_unit.sv
// Pulley constraint row prep: top level with front end, queue and back end.
//
// Usage:
//   item channel (item_valid/item_stall/item) takes two body poses per
//   transaction; result channel (result_valid/result_stall/result) returns one
//   constraint row per item, in order. cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes the anchors, local points, rest length and
//   pulley ratio; cfg_ready is always high, write only while the block is idle.
// Throughput: one item per cycle sustained while result_stall stays low.
// Pipeline: 4 transform stages, the queue, then the rope pipeline (2 setup
//   stages, 32 square root stages, 2 error stages, 20 divider stages and
//   2 angular stages; the last one is the result register). The square root
//   and the divider each resolve one bit per stage.
// Result stall freezes the rope pipeline; the 4-entry queue absorbs the front
//   end until it fills, then item_stall rises.
// Reset (rst, synchronous) empties all stages and the queue, sets anchors and
//   local points to zero, rest length to 1.0 and pulley ratio to 1.0.
module pulley_constraint_row_prep_unit import pcrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VEC_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic push, pop, fifo_full, fifo_valid;
  fq_t  push_data, head;

  pcrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .push       (push),
    .push_data  (push_data),
    .fifo_full  (fifo_full)
  );

  pcrp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .full  (fifo_full),
    .pop   (pop),
    .dout  (head),
    .valid (fifo_valid)
  );

  pcrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (fifo_valid),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_mode_matches_err: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.impulse_mode == MODE_ZERO) == (result.length_error == '0)))
    else $error("impulse mode disagrees with length error");

  a_zero_dir_zero_ang: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.direction_a == '0) |-> (result.angular_a == '0))
    else $error("angular term without rope direction");

  a_room_no_stall: assert property (@(posedge clk) disable iff (rst)
    !fifo_full |-> !item_stall)
    else $error("intake stalled with queue space left");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the pulley constraint row prep unit.
module tb_top;
  import pcrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 62;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_item_t item;
  logic result_valid;
  logic result_stall;
  out_item_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VEC_W-1:0] cfg_data;

  pulley_constraint_row_prep_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the configuration registers
  logic [VEC_W-1:0] sh_anchor_a, sh_anchor_b, sh_lp_a, sh_lp_b;
  logic [REST_W-1:0] sh_rest;
  logic [RATIO_W-1:0] sh_ratio;

  out_item_t expected_rows[$];
  int fail_count;
  longint cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_result;

  typedef longint vec3_t[3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sx(logic [63:0] v, int bits);
    logic [63:0] m;
    logic [63:0] s;
    m = (64'd1 << bits) - 64'd1;
    s = 64'd1 << (bits - 1);
    v = v & m;
    return longint'((v ^ s) - s);
  endfunction

  function automatic longint fl_shr(longint x, int n);
    if (x >= 0) return x >>> n;
    return -(((-x) - 1) >>> n) - 1;
  endfunction

  function automatic longint rnd_shr(longint x, int n);
    return fl_shr(x + (64'sd1 <<< (n - 1)), n);
  endfunction

  function automatic longint clamp(longint x, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic vec3_t unpack_vec(logic [63:0] w);
    vec3_t v;
    for (int i = 0; i < 3; i++) v[i] = sx(w >> (i * CW), CW);
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(vec3_t v);
    logic [63:0] r;
    r = 0;
    for (int i = 0; i < 3; i++) r |= (64'(v[i]) & ((64'd1 << CW) - 1)) << (i * CW);
    return r[VEC_W-1:0];
  endfunction

  function automatic vec3_t vcross(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic vec3_t body_to_world(logic [63:0] posw, logic [63:0] qw,
                                          logic [63:0] lpw);
    vec3_t p, v, q, t, u, o;
    longint w;
    longint acc;
    w = sx(qw >> 48, 16);
    p = unpack_vec(posw);
    v = unpack_vec(lpw);
    for (int i = 0; i < 3; i++) q[i] = sx(qw >> (16 * i), 16);
    t = vcross(q, v);
    u = vcross(q, t);
    for (int i = 0; i < 3; i++) begin
      acc = v[i] * (64'sd1 <<< 28) + 2 * (w * t[i] + u[i]);
      o[i] = clamp(p[i] + rnd_shr(acc, 28), CW);
    end
    return o;
  endfunction

  // unit direction toward the anchor; rope length at 20 fraction bits
  function automatic logic [63:0] rope_dir(vec3_t jp, logic [63:0] anchw,
                                           output vec3_t dir);
    vec3_t an, d;
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] mag;
    longint qv;
    an = unpack_vec(anchw);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = an[i] - jp[i];
      s += 64'(d[i] * d[i]);
    end
    len = int_sqrt(s << 20);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        dir[i] = 0;
      end else begin
        mag = 64'(d[i] < 0 ? -d[i] : d[i]) << (DIR_FRAC + FRAC_BITS);
        qv = longint'((2 * mag + len) / (2 * len));
        dir[i] = clamp(d[i] < 0 ? -qv : qv, CW);
      end
    end
    return len;
  endfunction

  function automatic logic [VEC_W-1:0] torque_arm(vec3_t jp, logic [63:0] posw, vec3_t dir);
    vec3_t p, rel, c;
    p = unpack_vec(posw);
    for (int i = 0; i < 3; i++) rel[i] = jp[i] - p[i];
    c = vcross(rel, dir);
    for (int i = 0; i < 3; i++) c[i] = clamp(rnd_shr(c[i], DIR_FRAC), CW);
    return pack_vec(c);
  endfunction

  function automatic out_item_t predict_row(in_item_t it);
    out_item_t r;
    vec3_t wa, wb, pa, off, da, db;
    logic [63:0] la, lb;
    longint err;
    wa = body_to_world(64'(it.position_a), it.rotation_a, 64'(sh_lp_a));
    wb = body_to_world(64'(it.position_b), it.rotation_b, 64'(sh_lp_b));
    pa = unpack_vec(64'(it.position_a));
    for (int i = 0; i < 3; i++) off[i] = clamp(wb[i] - pa[i], CW);
    la = rope_dir(wa, 64'(sh_anchor_a), da);
    lb = rope_dir(wb, 64'(sh_anchor_b), db);
    for (int i = 0; i < 3; i++) db[i] = clamp(-db[i], CW);
    err = longint'(64'(sh_rest) << 18) - longint'(la << 8) - longint'(lb * 64'(sh_ratio));
    err = clamp(rnd_shr(err, 18), ERR_W);
    r.world_point_a = pack_vec(wa);
    r.world_point_b = pack_vec(wb);
    r.offset_a = pack_vec(off);
    r.direction_a = pack_vec(da);
    r.angular_a = torque_arm(wa, 64'(it.position_a), da);
    r.direction_b = pack_vec(db);
    r.angular_b = torque_arm(wb, 64'(it.position_b), db);
    r.length_error = err[ERR_W-1:0];
    r.impulse_mode = err < 0 ? MODE_PUSH : (err > 0 ? MODE_PULL : MODE_ZERO);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // result side: stall and check
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row", 64'(result.impulse_mode), 64'd0);
        end else begin
          want = expected_rows.pop_front();
          if (result.world_point_a !== want.world_point_a)
            report_mismatch("world_point_a", 64'(result.world_point_a),
                            64'(want.world_point_a));
          if (result.world_point_b !== want.world_point_b)
            report_mismatch("world_point_b", 64'(result.world_point_b),
                            64'(want.world_point_b));
          if (result.offset_a !== want.offset_a)
            report_mismatch("offset_a", 64'(result.offset_a), 64'(want.offset_a));
          if (result.direction_a !== want.direction_a)
            report_mismatch("direction_a", 64'(result.direction_a), 64'(want.direction_a));
          if (result.angular_a !== want.angular_a)
            report_mismatch("angular_a", 64'(result.angular_a), 64'(want.angular_a));
          if (result.direction_b !== want.direction_b)
            report_mismatch("direction_b", 64'(result.direction_b), 64'(want.direction_b));
          if (result.angular_b !== want.angular_b)
            report_mismatch("angular_b", 64'(result.angular_b), 64'(want.angular_b));
          if (result.length_error !== want.length_error)
            report_mismatch("length_error", 64'(result.length_error),
                            64'(want.length_error));
          if (result.impulse_mode !== want.impulse_mode)
            report_mismatch("impulse_mode", 64'(result.impulse_mode),
                            64'(want.impulse_mode));
        end
      end
      result_stall <= hold_result || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_top failed");
      $finish;
    end
  end

  // valid stays high after the accept so items can follow back to back
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // transaction accepted at this edge
    expected_rows.push_back(predict_row(it));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[VEC_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ANCHOR_A: sh_anchor_a = val[VEC_W-1:0];
      CFG_ANCHOR_B: sh_anchor_b = val[VEC_W-1:0];
      CFG_LOCAL_POINT_A: sh_lp_a = val[VEC_W-1:0];
      CFG_LOCAL_POINT_B: sh_lp_b = val[VEC_W-1:0];
      CFG_REST_LENGTH: sh_rest = val[REST_W-1:0];
      CFG_PULLEY_RATIO: sh_ratio = val[RATIO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_vec(int mag);
    vec3_t v;
    for (int i = 0; i < 3; i++) v[i] = longint'($urandom_range(2 * mag)) - mag;
    return 64'(pack_vec(v)) | (64'($urandom_range(1)) << 63);
  endfunction

  function automatic logic [63:0] rand_quat();
    logic [63:0] q;
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      // near-unit: one dominant component with small noise
      q = 0;
      for (int i = 0; i < 4; i++)
        q[16*i +: 16] = 16'($signed($urandom_range(4000)) - 2000);
      q[16*$urandom_range(3) +: 16] = ($urandom_range(1) ? 16'sd16000 : -16'sd16000);
    end else begin
      q = {$urandom, $urandom};
    end
    return q;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int k;
    k = $urandom_range(9);
    it.position_a = (k == 0) ? VEC_W'({$urandom, $urandom}) : VEC_W'(rand_vec(4096));
    it.position_b = (k == 1) ? VEC_W'({$urandom, $urandom}) : VEC_W'(rand_vec(4096));
    it.rotation_a = rand_quat();
    it.rotation_b = rand_quat();
    return it;
  endfunction

  task automatic random_config();
    write_reg(CFG_ANCHOR_A, rand_vec($urandom_range(1) ? 20000 : 1000000));
    write_reg(CFG_ANCHOR_B, rand_vec(20000));
    write_reg(CFG_LOCAL_POINT_A, rand_vec($urandom_range(1) ? 3000 : 1000000));
    write_reg(CFG_LOCAL_POINT_B, rand_vec(3000));
    write_reg(CFG_REST_LENGTH, 64'($urandom_range(REST_W == 22 ? 4194303 : 0)));
    write_reg(CFG_PULLEY_RATIO, 64'($urandom_range(1023)));
  endtask

  task automatic test_directed();
    in_item_t it;
    logic [63:0] unit_q;
    unit_q = 64'h4000_0000_0000_0000;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // all zero: both ropes of zero length
    it = '0;
    it.rotation_a = unit_q;
    it.rotation_b = unit_q;
    send_item(it);
    it = '1;
    send_item(it);
    it.position_a = {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF};
    it.position_b = {1'b1, 21'h100000, 21'h0FFFFF, 21'h100000};
    it.rotation_a = 64'h7FFF_8000_7FFF_8000;
    it.rotation_b = 64'h8000_8000_8000_8000;
    send_item(it);
    drain();
    write_reg(CFG_ANCHOR_A, {1'b1, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    write_reg(CFG_ANCHOR_B, {1'b0, 21'h100000, 21'h100000, 21'h100000});
    write_reg(CFG_LOCAL_POINT_A, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    write_reg(CFG_LOCAL_POINT_B, {1'b1, 21'h100000, 21'h0FFFFF, 21'h100000});
    write_reg(CFG_REST_LENGTH, 64'h3FFFFF);
    write_reg(CFG_PULLEY_RATIO, 64'hFFFF);
    write_reg(3'd6, 64'h1234);
    write_reg(3'd7, '1);
    for (int i = 0; i < 6; i++) send_item(rand_item());
    it = '1;
    send_item(it);
    it = '0;
    send_item(it);
    drain();
    // exact zero error: rope A of length 1.0 along x, rope B of zero length
    write_reg(CFG_ANCHOR_A, 64'd1024);
    write_reg(CFG_ANCHOR_B, 64'd0);
    write_reg(CFG_LOCAL_POINT_A, 64'd0);
    write_reg(CFG_LOCAL_POINT_B, 64'd0);
    write_reg(CFG_REST_LENGTH, 64'd1024);
    write_reg(CFG_PULLEY_RATIO, 64'd0);
    it = '0;
    it.rotation_a = unit_q;
    it.rotation_b = unit_q;
    send_item(it);
    drain();
    write_reg(CFG_REST_LENGTH, 64'd1025);
    send_item(it);
    drain();
    write_reg(CFG_REST_LENGTH, 64'd1023);
    send_item(it);
    drain();
    write_reg(CFG_REST_LENGTH, 64'd0);
    write_reg(CFG_PULLEY_RATIO, 64'd256);
    send_item(it);
    drain();
  endtask

  task automatic random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    random_config();
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0 && i != 0 && $urandom_range(3) == 0) begin
        drain();
        random_config();
      end
      send_item(rand_item());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_result = 1'b1;
        repeat (300) @(posedge clk);
        hold_result = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_item(rand_item());
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_result = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count = 0;
    cycle_count = 0;
    sh_anchor_a = '0;
    sh_anchor_b = '0;
    sh_lp_a = '0;
    sh_lp_b = '0;
    sh_rest = REST_RESET;
    sh_ratio = RATIO_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    random_phase(260, 18, 64);
    random_phase(260, 64, 18);
    random_phase(160, 0, 0);
    test_backpressure();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/pcrp_pkg.sv
hw/rtl/pcrp_front.sv
hw/rtl/pcrp_fifo.sv
hw/rtl/pcrp_back.sv
hw/rtl/pulley_constraint_row_prep_unit.sv
dv/tb_top.sv
